>>> design/srcp_pkg.sv
// ----------------------------------------------------------------------------
// srcp_pkg
// Shared types, codes and constants of the strand read coverage profile unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srcp_pkg;

    localparam int MAX_FRAGMENT_DEF = 65536;
    localparam int STAT_W           = 40;
    localparam int CFG_DW           = 17;
    localparam int CFG_IW           = 1;

    typedef logic [3:0] t_flags;
    typedef logic [4:0] t_stat_idx;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  cigar_op;
        logic [15:0] read_start;
        logic        read_strand;
        logic [7:0]  read_hits;
        logic        last_op;
    } t_in_item;

    typedef struct packed {
        t_stat_idx         stat_index;
        logic [STAT_W-1:0] stat_value;
        logic              last_stat;
    } t_out_item;

    typedef struct packed {
        logic [31:0] reads;
        logic [31:0] uniq_reads;
        logic [31:0] same_reads;
        logic [31:0] same_uniq_reads;
        logic [39:0] ms_all;
        logic [39:0] ms_uniq;
        logic [39:0] ms_same;
        logic [39:0] ms_same_uniq;
        logic [39:0] ms_opp;
        logic [39:0] ms_opp_uniq;
        logic [31:0] out_of_range;
    } t_counts;

    typedef struct packed {
        logic upd;
        logic sweep;
        logic walk;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_RUN,
        S_DRAIN_FIN,
        S_DRAIN_CLR,
        S_WALK,
        S_REPORT
    } t_state;

    localparam logic [1:0] ACT_CIGAR = 2'd0;
    localparam logic [1:0] ACT_FINAL = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] OP_UNKNOWN  = 3'd0;
    localparam logic [2:0] OP_MATCH    = 3'd1;
    localparam logic [2:0] OP_DELETION = 3'd3;

    localparam t_flags FLAG_UNIQ_SAME = 4'b0001;
    localparam t_flags FLAG_MULT_SAME = 4'b0010;
    localparam t_flags FLAG_UNIQ_OPP  = 4'b0100;
    localparam t_flags FLAG_MULT_OPP  = 4'b1000;

    localparam logic [CFG_IW-1:0] CFG_STRAND = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_LENGTH = 1'd1;

    localparam t_stat_idx STAT_COVERED       = 5'd0;
    localparam t_stat_idx STAT_UNIQ_POS      = 5'd1;
    localparam t_stat_idx STAT_SAME_POS      = 5'd2;
    localparam t_stat_idx STAT_SAME_UNIQ_POS = 5'd3;
    localparam t_stat_idx STAT_OPP_POS       = 5'd4;
    localparam t_stat_idx STAT_OPP_UNIQ_POS  = 5'd5;
    localparam t_stat_idx STAT_READS         = 5'd6;
    localparam t_stat_idx STAT_UNIQ_READS    = 5'd7;
    localparam t_stat_idx STAT_SAME_READS    = 5'd8;
    localparam t_stat_idx STAT_SAME_UNIQ_RD  = 5'd9;
    localparam t_stat_idx STAT_MS_ALL        = 5'd10;
    localparam t_stat_idx STAT_MS_UNIQ       = 5'd11;
    localparam t_stat_idx STAT_MS_SAME       = 5'd12;
    localparam t_stat_idx STAT_MS_SAME_UNIQ  = 5'd13;
    localparam t_stat_idx STAT_MS_OPP        = 5'd14;
    localparam t_stat_idx STAT_MS_OPP_UNIQ   = 5'd15;
    localparam t_stat_idx STAT_OUT_OF_RANGE  = 5'd16;
    localparam t_stat_idx STAT_LAST          = 5'd16;

endpackage

`default_nettype wire

>>> design/strand_read_coverage_profile_unit.sv
// ----------------------------------------------------------------------------
// strand_read_coverage_profile_unit
// Strand-aware read coverage profile: cigar operations set flag bits in a
// per-position profile memory, finalize walks it and reports 17 statistics.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      i_in_valid/o_in_stall   t_in_item
//  out      output     o_out_valid/i_out_stall t_out_item
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  cigar operation items: one per cycle, read-modify-write of the flag memory
//  finalize: a drain state, a walk of the flag memory over the window, then 17 items
//  clear: a drain state plus a sweep of all MAX_FRAGMENT flag memory entries
//  after reset the same sweep runs before the first item
//  input stalls during drain, sweep, walk and report; cfg is always ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module strand_read_coverage_profile_unit #(
    parameter int MAX_FRAGMENT = srcp_pkg::MAX_FRAGMENT_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  srcp_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output srcp_pkg::t_out_item             o_out_item,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [srcp_pkg::CFG_IW-1:0]     i_cfg_index,
    input  wire  [srcp_pkg::CFG_DW-1:0]     i_cfg_data
);
    import srcp_pkg::*;

    localparam int AW  = $clog2(MAX_FRAGMENT);
    localparam int LW  = $clog2(MAX_FRAGMENT + 1);
    localparam int WLW = (LW > 17) ? LW : 17;
    localparam int CW  = LW + 1;

    t_state                r_state;
    t_state                n_state;
    logic [WLW-1:0]        r_cnt;
    logic [WLW-1:0]        n_cnt;
    t_stat_idx             r_idx;
    t_stat_idx             n_idx;
    logic                  r_rd_vld;
    logic [CW-1:0]         r_cov [6];
    logic                  r_frag_strand;
    logic [CFG_DW-1:0]     r_frag_len;

    logic [WLW-1:0]        frag_x;
    logic [WLW-1:0]        win;
    logic                  trk_clr;
    logic                  trk_acc;
    logic                  cov_clr;
    logic                  out_load;
    logic                  out_free;
    t_mem_ctl              mem_ctl;
    logic                  upd_vld;
    logic [AW-1:0]         upd_addr;
    t_flags                upd_bits;
    t_flags                rd_data;
    t_counts               counts;
    logic [5:0][STAT_W-1:0] cov40;

    always_comb begin
        frag_x = WLW'(r_frag_len);
        win    = (frag_x < WLW'(MAX_FRAGMENT)) ? frag_x : WLW'(MAX_FRAGMENT);
        for (int k = 0; k < 6; k++) begin
            cov40[k] = STAT_W'(r_cov[k]);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        o_in_stall = 1'b1;
        trk_clr    = 1'b0;
        trk_acc    = 1'b0;
        cov_clr    = 1'b0;
        out_load   = 1'b0;
        mem_ctl    = '0;
        unique case (r_state)
            S_SWEEP: begin
                mem_ctl.sweep = 1'b1;
                n_cnt         = r_cnt + WLW'(1);
                if (r_cnt == WLW'(MAX_FRAGMENT - 1)) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    unique case (i_in_item.action)
                        ACT_CIGAR: trk_acc = 1'b1;
                        ACT_FINAL: n_state = S_DRAIN_FIN;
                        ACT_CLEAR: begin
                            trk_clr = 1'b1;
                            n_state = S_DRAIN_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_DRAIN_FIN: begin
                cov_clr = 1'b1;
                n_cnt   = '0;
                n_state = S_WALK;
            end
            S_DRAIN_CLR: begin
                n_cnt   = '0;
                n_state = S_SWEEP;
            end
            S_WALK: begin
                if (r_cnt < win) begin
                    mem_ctl.walk = 1'b1;
                    n_cnt        = r_cnt + WLW'(1);
                end else if (!r_rd_vld) begin
                    n_state = S_REPORT;
                    n_idx   = '0;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_idx    = r_idx + 5'd1;
                    if (r_idx == STAT_LAST) begin
                        n_state = S_RUN;
                    end
                end
            end
            default: n_state = S_SWEEP;
        endcase
        mem_ctl.upd = upd_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_cnt         <= '0;
            r_idx         <= '0;
            r_rd_vld      <= 1'b0;
            r_frag_strand <= 1'b1;
            r_frag_len    <= CFG_DW'(65536);
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_rd_vld <= mem_ctl.walk;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STRAND: r_frag_strand <= i_cfg_data[0];
                    CFG_LENGTH: r_frag_len    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cov_clr) begin
            for (int k = 0; k < 6; k++) begin
                r_cov[k] <= '0;
            end
        end else if (r_rd_vld) begin
            r_cov[0] <= r_cov[0] + CW'(rd_data != '0);
            r_cov[1] <= r_cov[1] + CW'(rd_data[0] | rd_data[2]);
            r_cov[2] <= r_cov[2] + CW'(rd_data[1]) + CW'(rd_data[0]);
            r_cov[3] <= r_cov[3] + CW'(rd_data[0]);
            r_cov[4] <= r_cov[4] + CW'(rd_data[3]) + CW'(rd_data[2]);
            r_cov[5] <= r_cov[5] + CW'(rd_data[2]);
        end
    end

    assign o_cfg_ready = 1'b1;

    srcp_read_track #(
        .MAX_FRAGMENT (MAX_FRAGMENT)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clr         (trk_clr),
        .i_acc         (trk_acc),
        .i_item        (i_in_item),
        .i_frag_strand (r_frag_strand),
        .i_window      (win),
        .o_counts      (counts),
        .o_upd_vld     (upd_vld),
        .o_upd_addr    (upd_addr),
        .o_upd_bits    (upd_bits)
    );

    srcp_flag_mem #(
        .MAX_FRAGMENT (MAX_FRAGMENT)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mem_ctl),
        .i_upd_addr  (upd_addr),
        .i_upd_bits  (upd_bits),
        .i_scan_addr (r_cnt[AW-1:0]),
        .o_rd_data   (rd_data)
    );

    srcp_stat_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_idx    (r_idx),
        .i_cov    (cov40),
        .i_counts (counts),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item),
        .o_free   (out_free)
    );

    // sweep never shares the write port with a pending match update
    a_sweep_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !$past(trk_acc))
        else $error("sweep overlaps a match update");

    a_walk_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cnt <= win))
        else $error("walk beyond window");

    a_report_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT) |-> (r_idx <= STAT_LAST))
        else $error("report index overrun");

    a_last_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last_stat) |-> (o_out_item.stat_index == STAT_LAST))
        else $error("last item mark on wrong statistic");

endmodule

`default_nettype wire

>>> design/srcp_flag_mem.sv
// ----------------------------------------------------------------------------
// srcp_flag_mem
// Coverage flag memory with a read-modify-write stage for match updates,
// one-deep forwarding of the last write, and a scan port for sweep and walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srcp_flag_mem #(
    parameter int   MAX_FRAGMENT = srcp_pkg::MAX_FRAGMENT_DEF,
    localparam int  AW           = $clog2(MAX_FRAGMENT)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  srcp_pkg::t_mem_ctl       i_ctl,
    input  wire  [AW-1:0]            i_upd_addr,
    input  srcp_pkg::t_flags         i_upd_bits,
    input  wire  [AW-1:0]            i_scan_addr,
    output srcp_pkg::t_flags         o_rd_data
);
    import srcp_pkg::*;

    t_flags          r_mem [MAX_FRAGMENT];
    t_flags          r_rd_data;

    logic            r_s1_vld;
    logic [AW-1:0]   r_s1_addr;
    t_flags          r_s1_bits;
    logic            r_fw_vld;
    logic [AW-1:0]   r_fw_addr;
    t_flags          r_fw_data;

    logic            we;
    logic [AW-1:0]   waddr;
    t_flags          wdata;
    t_flags          merged;
    logic            re;
    logic [AW-1:0]   raddr;

    always_comb begin
        merged = ((r_fw_vld && (r_fw_addr == r_s1_addr)) ? r_fw_data : r_rd_data) | r_s1_bits;
        we     = r_s1_vld || i_ctl.sweep;
        waddr  = r_s1_vld ? r_s1_addr : i_scan_addr;
        wdata  = r_s1_vld ? merged : '0;
        re     = i_ctl.upd || i_ctl.walk;
        raddr  = i_ctl.upd ? i_upd_addr : i_scan_addr;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.upd;
            r_fw_vld <= r_s1_vld;
        end
        r_s1_addr <= i_upd_addr;
        r_s1_bits <= i_upd_bits;
        r_fw_addr <= r_s1_addr;
        r_fw_data <= merged;
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/srcp_read_track.sv
// ----------------------------------------------------------------------------
// srcp_read_track
// Per-read walk over cigar operations, profile update requests, and the
// saturating read, match and out-of-range counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srcp_read_track #(
    parameter int   MAX_FRAGMENT = srcp_pkg::MAX_FRAGMENT_DEF,
    localparam int  AW           = $clog2(MAX_FRAGMENT),
    localparam int  LW           = $clog2(MAX_FRAGMENT + 1),
    localparam int  WLW          = (LW > 17) ? LW : 17
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_clr,
    input  wire                      i_acc,
    input  srcp_pkg::t_in_item       i_item,
    input  wire                      i_frag_strand,
    input  wire  [WLW-1:0]           i_window,
    output srcp_pkg::t_counts        o_counts,
    output logic                     o_upd_vld,
    output logic [AW-1:0]            o_upd_addr,
    output srcp_pkg::t_flags         o_upd_bits
);
    import srcp_pkg::*;

    localparam int PW = (WLW > 18) ? WLW : 18;

    logic [16:0]   r_walk;
    logic [15:0]   r_mcount;
    t_counts       r_counts;
    logic [16:0]   n_walk;
    logic [15:0]   n_mcount;
    t_counts       n_counts;

    logic          is_move;
    logic          is_match;
    logic          same;
    logic          multi;
    logic          in_win;
    logic [17:0]   pos;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] win_x;

    function automatic logic [31:0] inc32(input logic [31:0] a);
        inc32 = (a == '1) ? a : a + 32'd1;
    endfunction

    function automatic logic [39:0] add40(input logic [39:0] a, input logic [15:0] b);
        logic [40:0] s;
        s     = {1'b0, a} + {25'd0, b};
        add40 = s[40] ? '1 : s[39:0];
    endfunction

    always_comb begin
        is_match = (i_item.cigar_op == OP_MATCH);
        is_move  = is_match || (i_item.cigar_op == OP_UNKNOWN)
                 || (i_item.cigar_op == OP_DELETION);
        same     = (i_item.read_strand == i_frag_strand);
        multi    = (i_item.read_hits > 8'd1);
        pos      = {2'b00, i_item.read_start} + {1'b0, r_walk};
        pos_x    = PW'(pos);
        win_x    = PW'(i_window);
        in_win   = (pos_x < win_x);

        o_upd_vld  = i_acc && is_match && in_win;
        o_upd_addr = pos_x[AW-1:0];
        if (same) begin
            o_upd_bits = multi ? FLAG_MULT_SAME : FLAG_UNIQ_SAME;
        end else begin
            o_upd_bits = multi ? FLAG_MULT_OPP : FLAG_UNIQ_OPP;
        end

        n_counts = r_counts;
        n_mcount = r_mcount;
        n_walk   = r_walk;
        if (is_match) begin
            if (!in_win) begin
                n_counts.out_of_range = inc32(r_counts.out_of_range);
            end
            if (r_mcount != '1) begin
                n_mcount = r_mcount + 16'd1;
            end
        end
        if (is_move && (r_walk != '1)) begin
            n_walk = r_walk + 17'd1;
        end
        if (i_item.last_op) begin
            n_counts.reads  = inc32(r_counts.reads);
            n_counts.ms_all = add40(r_counts.ms_all, n_mcount);
            if (same) begin
                n_counts.same_reads = inc32(r_counts.same_reads);
                n_counts.ms_same    = add40(r_counts.ms_same, n_mcount);
            end else begin
                n_counts.ms_opp = add40(r_counts.ms_opp, n_mcount);
            end
            if (!multi) begin
                n_counts.uniq_reads = inc32(r_counts.uniq_reads);
                n_counts.ms_uniq    = add40(r_counts.ms_uniq, n_mcount);
                if (same) begin
                    n_counts.same_uniq_reads = inc32(r_counts.same_uniq_reads);
                    n_counts.ms_same_uniq    = add40(r_counts.ms_same_uniq, n_mcount);
                end else begin
                    n_counts.ms_opp_uniq = add40(r_counts.ms_opp_uniq, n_mcount);
                end
            end
            n_walk   = '0;
            n_mcount = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_walk   <= '0;
            r_mcount <= '0;
            r_counts <= '0;
        end else if (i_acc) begin
            r_walk   <= n_walk;
            r_mcount <= n_mcount;
            r_counts <= n_counts;
        end
    end

    assign o_counts = r_counts;

endmodule

`default_nettype wire

>>> design/srcp_stat_out.sv
// ----------------------------------------------------------------------------
// srcp_stat_out
// Statistic select and output register of the report channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srcp_stat_out (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_load,
    input  srcp_pkg::t_stat_idx                  i_idx,
    input  wire  [5:0][srcp_pkg::STAT_W-1:0]     i_cov,
    input  srcp_pkg::t_counts                    i_counts,
    input  wire                                  i_stall,
    output logic                                 o_valid,
    output srcp_pkg::t_out_item                  o_item,
    output logic                                 o_free
);
    import srcp_pkg::*;

    logic              r_vld;
    t_out_item         r_item;
    logic [STAT_W-1:0] value;

    always_comb begin
        unique case (i_idx)
            STAT_COVERED:       value = i_cov[0];
            STAT_UNIQ_POS:      value = i_cov[1];
            STAT_SAME_POS:      value = i_cov[2];
            STAT_SAME_UNIQ_POS: value = i_cov[3];
            STAT_OPP_POS:       value = i_cov[4];
            STAT_OPP_UNIQ_POS:  value = i_cov[5];
            STAT_READS:         value = STAT_W'(i_counts.reads);
            STAT_UNIQ_READS:    value = STAT_W'(i_counts.uniq_reads);
            STAT_SAME_READS:    value = STAT_W'(i_counts.same_reads);
            STAT_SAME_UNIQ_RD:  value = STAT_W'(i_counts.same_uniq_reads);
            STAT_MS_ALL:        value = i_counts.ms_all;
            STAT_MS_UNIQ:       value = i_counts.ms_uniq;
            STAT_MS_SAME:       value = i_counts.ms_same;
            STAT_MS_SAME_UNIQ:  value = i_counts.ms_same_uniq;
            STAT_MS_OPP:        value = i_counts.ms_opp;
            STAT_MS_OPP_UNIQ:   value = i_counts.ms_opp_uniq;
            STAT_OUT_OF_RANGE:  value = STAT_W'(i_counts.out_of_range);
            default:            value = '0;
        endcase
        o_free = !r_vld || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
        if (i_load) begin
            r_item.stat_index <= i_idx;
            r_item.stat_value <= value;
            r_item.last_stat  <= (i_idx == STAT_LAST);
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strand read coverage profile unit. A scoreboard
// class keeps its own copy of the flag profile and counters, predicts the 17
// statistics of every finalize and compares each reported item field by field.
// Reads stream through as cigar operations under several strand and length
// settings, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import srcp_pkg::*;

    localparam int     MAX_FRAG      = MAX_FRAGMENT_DEF;
    localparam int     CLK_PERIOD    = 8;
    localparam int     RESET_CYCLES  = 5;
    localparam int     SETTLE_CYCLES = 64;
    localparam longint CYCLE_LIMIT   = 3000000;

    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam logic [2:0] OP_INSERTION = 3'd2;
    localparam logic [2:0] OP_SOFT_CLIP = 3'd4;

    class profile_scoreboard;
        t_out_item stats_due[$];
        int        errors;
        bit [3:0]  profile[];
        bit        frag_strand;
        bit [16:0] frag_len;
        bit [16:0] walk;
        bit [15:0] read_matches;
        bit [31:0] read_tally[4];
        bit [39:0] match_tally[6];
        bit [31:0] off_window;

        function new();
            profile = new[MAX_FRAG];
            errors = 0;
            frag_strand = 1'b1;
            frag_len = 17'(MAX_FRAG);
            wipe();
        endfunction

        function void wipe();
            foreach (profile[i]) profile[i] = '0;
            walk = '0;
            read_matches = '0;
            read_tally = '{default: '0};
            match_tally = '{default: '0};
            off_window = '0;
        endfunction

        function int window();
            return (int'(frag_len) < MAX_FRAG) ? int'(frag_len) : MAX_FRAG;
        endfunction

        function bit [31:0] inc32(bit [31:0] v);
            return (v == '1) ? v : v + 32'd1;
        endfunction

        function bit [39:0] add40(bit [39:0] a, bit [15:0] b);
            bit [40:0] s;
            s = {1'b0, a} + 41'(b);
            return s[40] ? '1 : s[39:0];
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            if (idx == CFG_STRAND) frag_strand = data[0];
            else if (idx == CFG_LENGTH) frag_len = data;
        endfunction

        function void apply_cigar(t_in_item it);
            bit          same;
            bit          multi;
            int unsigned pos;
            bit [3:0]    mark;
            same = (it.read_strand == frag_strand);
            multi = (it.read_hits > 8'd1);
            if (it.cigar_op == OP_UNKNOWN || it.cigar_op == OP_MATCH ||
                it.cigar_op == OP_DELETION) begin
                if (it.cigar_op == OP_MATCH) begin
                    pos = 32'(it.read_start) + 32'(walk);
                    if (pos < window()) begin
                        if (same) mark = multi ? FLAG_MULT_SAME : FLAG_UNIQ_SAME;
                        else mark = multi ? FLAG_MULT_OPP : FLAG_UNIQ_OPP;
                        profile[pos] = profile[pos] | mark;
                    end else begin
                        off_window = inc32(off_window);
                    end
                    if (read_matches != '1) read_matches++;
                end
                if (walk != '1) walk++;
            end
            if (it.last_op) begin
                read_tally[0] = inc32(read_tally[0]);
                match_tally[0] = add40(match_tally[0], read_matches);
                if (same) begin
                    read_tally[2] = inc32(read_tally[2]);
                    match_tally[2] = add40(match_tally[2], read_matches);
                end else begin
                    match_tally[4] = add40(match_tally[4], read_matches);
                end
                if (!multi) begin
                    read_tally[1] = inc32(read_tally[1]);
                    match_tally[1] = add40(match_tally[1], read_matches);
                    if (same) begin
                        read_tally[3] = inc32(read_tally[3]);
                        match_tally[3] = add40(match_tally[3], read_matches);
                    end else begin
                        match_tally[5] = add40(match_tally[5], read_matches);
                    end
                end
                walk = '0;
                read_matches = '0;
            end
        endfunction

        function void report_stats();
            bit [39:0]   vals[STAT_LAST + 1];
            int unsigned cov[6];
            bit [3:0]    f;
            int          n;
            t_out_item   o;
            cov = '{default: 0};
            n = window();
            for (int i = 0; i < n; i++) begin
                f = profile[i];
                if (f == '0) continue;
                cov[0]++;
                if ((f & (FLAG_UNIQ_SAME | FLAG_UNIQ_OPP)) != '0) cov[1]++;
                if ((f & FLAG_MULT_SAME) != '0) cov[2]++;
                if ((f & FLAG_UNIQ_SAME) != '0) begin
                    cov[2]++;
                    cov[3]++;
                end
                if ((f & FLAG_MULT_OPP) != '0) cov[4]++;
                if ((f & FLAG_UNIQ_OPP) != '0) begin
                    cov[4]++;
                    cov[5]++;
                end
            end
            for (int k = 0; k < 6; k++) vals[STAT_COVERED + k] = 40'(cov[k]);
            for (int k = 0; k < 4; k++) vals[STAT_READS + k] = 40'(read_tally[k]);
            for (int k = 0; k < 6; k++) vals[STAT_MS_ALL + k] = match_tally[k];
            vals[STAT_OUT_OF_RANGE] = 40'(off_window);
            for (int k = 0; k <= STAT_LAST; k++) begin
                o.stat_index = t_stat_idx'(k);
                o.stat_value = vals[k];
                o.last_stat = (k == STAT_LAST);
                stats_due.push_back(o);
            end
        endfunction

        function void note_item(t_in_item it);
            case (it.action)
                ACT_CIGAR: apply_cigar(it);
                ACT_FINAL: report_stats();
                ACT_CLEAR: wipe();
                default: ;
            endcase
        endfunction

        function void check_stat(t_out_item got);
            t_out_item want;
            if (stats_due.size() == 0) begin
                $display("%0t unexpected item: expected none, actual index %0d value %0d",
                         $time, got.stat_index, got.stat_value);
                errors++;
                return;
            end
            want = stats_due.pop_front();
            if (got.stat_index !== want.stat_index) begin
                $display("%0t stat_index: expected %0d actual %0d",
                         $time, want.stat_index, got.stat_index);
                errors++;
            end
            if (got.stat_value !== want.stat_value) begin
                $display("%0t stat_value of %0d: expected %0d actual %0d",
                         $time, want.stat_index, want.stat_value, got.stat_value);
                errors++;
            end
            if (got.last_stat !== want.last_stat) begin
                $display("%0t last_stat of %0d: expected %0d actual %0d",
                         $time, want.stat_index, want.last_stat, got.last_stat);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    t_in_item            in_item = '0;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out_item           o_out_item;
    logic                o_cfg_ready;

    profile_scoreboard   sb;
    bit                  sweep_pending = 1'b1;
    int                  calm_in = 0;
    int                  calm_out = 0;
    int                  stall_left = 0;
    int                  r_out;
    longint              cycle_count = 0;

    strand_read_coverage_profile_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) sb.check_stat(o_out_item);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (calm_out > 0) begin
            calm_out--;
        end else begin
            r_out = $urandom_range(0, 99);
            if (r_out < 8) calm_out = $urandom_range(20, 150);
            else if (r_out < 45) stall_left = pick_gap();
        end
        out_stall <= (stall_left > 0);
    end

    function automatic t_in_item op_item(logic [2:0] op, logic [15:0] start,
                                         logic strand, logic [7:0] hits, logic last);
        t_in_item it;
        it.action = ACT_CIGAR;
        it.cigar_op = op;
        it.read_start = start;
        it.read_strand = strand;
        it.read_hits = hits;
        it.last_op = last;
        return it;
    endfunction

    function automatic t_in_item cmd_item(logic [1:0] act);
        t_in_item it;
        it = op_item(3'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
                     1'($urandom));
        it.action = act;
        return it;
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return OP_MATCH;
        if (r < 65) return OP_UNKNOWN;
        if (r < 75) return OP_DELETION;
        if (r < 83) return OP_INSERTION;
        if (r < 90) return OP_SOFT_CLIP;
        return OP_SOFT_CLIP + 3'($urandom_range(1, 3));
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        int r;
        gap = 0;
        if (calm_in > 0) begin
            calm_in--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 5) calm_in = $urandom_range(10, 30);
            else if (r >= 50) gap = pick_gap();
        end
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (o_in_stall);
        sb.note_item(it);
        if (it.action == ACT_CLEAR) sweep_pending = 1'b1;
        else if (it.action == ACT_FINAL) sweep_pending = 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.stats_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input logic strand, input logic [CFG_DW-1:0] length);
        wait_drained();
        repeat (sweep_pending ? MAX_FRAG + SETTLE_CYCLES : SETTLE_CYCLES) @(posedge clk);
        sweep_pending = 1'b0;
        write_reg(CFG_STRAND, CFG_DW'(strand));
        write_reg(CFG_LENGTH, length);
    endtask

    // well-formed reads with random content, plus stray and broken ones
    task automatic run_reads(input int quota, input bit add_clear);
        int         sent;
        int         nops;
        int         r;
        int         win;
        bit         cleared;
        bit         broken;
        logic [15:0] start;
        logic       strand;
        logic [7:0] hits;
        win = sb.window();
        sent = 0;
        cleared = 1'b0;
        while (sent < quota) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_item(cmd_item(ACT_NONE));
            end else if (r < 12 && win <= 4096) begin
                send_item(cmd_item(ACT_FINAL));
                sent++;
                if ($urandom_range(0, 2) == 0) wait_drained();
            end else begin
                nops = $urandom_range(1, 6);
                if ($urandom_range(0, 99) < 85)
                    start = 16'($urandom_range(0, (win > 65531) ? 65535 : win + 4));
                else
                    start = 16'($urandom);
                strand = 1'($urandom);
                r = $urandom_range(0, 99);
                hits = (r < 45) ? 8'd1 : ((r < 55) ? 8'd0 : 8'($urandom_range(2, 255)));
                broken = ($urandom_range(0, 99) < 10);
                for (int k = 0; k < nops; k++) begin
                    if (win <= 4096 && $urandom_range(0, 99) < 3) begin
                        send_item(cmd_item(ACT_FINAL));
                        sent++;
                    end
                    send_item(op_item(pick_op(), start, strand, hits,
                                      (k == nops - 1) && !broken));
                    sent++;
                end
            end
            if (add_clear && !cleared && sent >= quota / 2) begin
                send_item(cmd_item(ACT_CLEAR));
                cleared = 1'b1;
                sent++;
            end
        end
        send_item(cmd_item(ACT_FINAL));
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // window edge, ignored codes, overlapping flags, zero hits
        start_phase(1'b1, 17'(MAX_FRAG));
        send_item(op_item(OP_MATCH, 16'd65534, 1'b1, 8'd1, 1'b0));
        send_item(op_item(OP_MATCH, 16'd65534, 1'b1, 8'd1, 1'b0));
        send_item(op_item(OP_MATCH, 16'd65534, 1'b1, 8'd1, 1'b0));
        send_item(op_item(OP_INSERTION, 16'd65534, 1'b1, 8'd1, 1'b0));
        send_item(op_item(OP_SOFT_CLIP, 16'd65534, 1'b1, 8'd1, 1'b0));
        send_item(op_item(OP_DELETION, 16'd65534, 1'b1, 8'd1, 1'b0));
        send_item(op_item(OP_SOFT_CLIP + 3'd1, 16'd65534, 1'b1, 8'd1, 1'b0));
        send_item(op_item(OP_SOFT_CLIP + 3'd2, 16'd65534, 1'b1, 8'd1, 1'b0));
        send_item(op_item(OP_SOFT_CLIP + 3'd3, 16'd65534, 1'b1, 8'd1, 1'b1));
        send_item(op_item(OP_MATCH, 16'd0, 1'b0, 8'd255, 1'b0));
        send_item(op_item(OP_UNKNOWN, 16'd0, 1'b0, 8'd255, 1'b0));
        send_item(op_item(OP_MATCH, 16'd0, 1'b0, 8'd255, 1'b1));
        send_item(op_item(OP_MATCH, 16'd0, 1'b1, 8'd0, 1'b1));
        send_item(op_item(OP_MATCH, 16'd0, 1'b1, 8'd2, 1'b1));
        send_item(cmd_item(ACT_FINAL));
        send_item(cmd_item(ACT_NONE));

        // empty window, finalize and clear in the middle of a read
        start_phase(1'b0, '0);
        send_item(op_item(OP_MATCH, 16'd0, 1'b0, 8'd1, 1'b1));
        send_item(op_item(OP_MATCH, 16'd5, 1'b1, 8'd1, 1'b0));
        send_item(cmd_item(ACT_FINAL));
        send_item(op_item(OP_DELETION, 16'd5, 1'b1, 8'd1, 1'b1));
        send_item(op_item(OP_MATCH, 16'd7, 1'b0, 8'd3, 1'b0));
        send_item(cmd_item(ACT_CLEAR));
        send_item(op_item(OP_MATCH, 16'd7, 1'b0, 8'd3, 1'b1));
        send_item(cmd_item(ACT_FINAL));

        start_phase(1'b0, 17'($urandom_range(2, 300)));
        run_reads(18, 1'b0);
        start_phase(1'b1, 17'd1);
        run_reads(10, 1'b0);
        start_phase(1'($urandom), 17'($urandom_range(16, 512)));
        run_reads(18, 1'b1);
        start_phase(1'b1, '1);
        run_reads(10, 1'b0);
        start_phase(1'b0, 17'($urandom_range(1, 64)));
        run_reads(18, 1'b0);
        start_phase(1'($urandom), 17'($urandom_range(100, 1000)));
        run_reads(18, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.stats_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
